// File: hw/rtl/ilb_pkg.sv
// Shared types, codes and command/status structs for the indexed list buffer.
`default_nettype none

package ilb_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned INDEX_W = 7;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned ACT_W   = 3;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [INDEX_W-1:0]        index_type;
   typedef logic [COUNT_W-1:0]        count_type;
   typedef logic [ACT_W-1:0]          action_type;

   // Request action codes; codes above ACT_ERASE are ignored.
   localparam action_type ACT_GET    = 3'd0;
   localparam action_type ACT_SET    = 3'd1;
   localparam action_type ACT_APPEND = 3'd2;
   localparam action_type ACT_INSERT = 3'd3;
   localparam action_type ACT_ERASE  = 3'd4;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   localparam count_type CAP_RESET = 7'd64;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // latch the incoming request
      logic rd;         // read one element into the read register
      logic ptr_init;   // start the shift pointer
      logic shift_wr;   // write the read element one place over, step the pointer
      logic commit;     // final write, count update and result capture
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ok;          // request passes its checks
      logic is_get;
      logic is_shift;    // insert or erase
      logic shift_more;  // another element still has to move
   } dp_sts_type;

endpackage

`default_nettype wire

// File: hw/rtl/ilb_req_if.sv
// Request channel interface of the indexed list buffer.
`default_nettype none

interface ilb_req_if import ilb_pkg::*; ();
   logic       valid;
   logic       ready;
   action_type action;
   index_type  index;
   value_type  value;

   modport source (output valid, output action, output index, output value, input ready);
   modport sink   (input valid, input action, input index, input value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ilb_rsp_if.sv
// Response channel interface of the indexed list buffer.
`default_nettype none

interface ilb_rsp_if import ilb_pkg::*; ();
   logic       valid;
   logic       ready;
   value_type  read_value;
   status_type status;
   count_type  count;

   modport source (output valid, output read_value, output status, output count, input ready);
   modport sink   (input valid, input read_value, input status, input count, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/indexed_list_buffer_unit.sv
// Top level of the indexed list buffer: a bounded ordered list of signed words.
// Get, set, append and any failed request go from accept through check and commit to the
// response, which is held until taken; the next request is accepted after that.
// Insert and erase add a read and a write state per moved element, then a last read state:
// the store has one write and one registered read port, so each move reads then writes one entry.
// Reset (synchronous, active high) empties the list and sets the capacity to 64.
`default_nettype none

module indexed_list_buffer_unit import ilb_pkg::*; #(
   parameter int unsigned DEPTH = 64
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      csr_wr_en,
   input  wire count_type csr_wr_data,
   ilb_req_if.sink        req_bus,
   ilb_rsp_if.source      rsp_bus
);

   // The controller and datapath talk only through these two structs.
   dp_cmd_type cmd;
   dp_sts_type sts;

   // The controller walks each request through check, optional element moves,
   // commit and response, and holds the handshake outputs in registers.
   ilb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The datapath owns the element store, the count and the capacity register.
   // The response payload comes straight from its result registers, which hold
   // steady while the response waits to be taken.
   ilb_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_action     (req_bus.action),
      .req_index      (req_bus.index),
      .req_value      (req_bus.value),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_read_value (rsp_bus.read_value),
      .rsp_status     (rsp_bus.status),
      .rsp_count      (rsp_bus.count)
   );

endmodule

`default_nettype wire

// File: hw/rtl/ilb_ctrl.sv
// Controller state machine that sequences each request through the datapath.
`default_nettype none

module ilb_ctrl import ilb_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   output dp_cmd_type  cmd,
   input  wire dp_sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SH_RD,
      S_SH_WR,
      S_COMMIT,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.rd = sts.ok && sts.is_get;
            if (sts.ok && sts.is_shift) begin
               cmd.ptr_init = 1'b1;
               state_in     = S_SH_RD;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_SH_RD: begin
            if (sts.shift_more) begin
               cmd.rd   = 1'b1;
               state_in = S_SH_WR;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_SH_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SH_RD;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == S_IDLE);
         rsp_valid_ff <= (state_in == S_RESP);
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ilb_datapath.sv
// Element store, count, capacity register, request checks and result registers.
`default_nettype none

module ilb_datapath import ilb_pkg::*; #(
   parameter int unsigned DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire count_type   csr_wr_data,
   input  wire action_type  req_action,
   input  wire index_type   req_index,
   input  wire value_type   req_value,
   input  wire dp_cmd_type  cmd,
   output dp_sts_type       sts,
   output value_type        rsp_read_value,
   output status_type       rsp_status,
   output count_type        rsp_count
);

   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   value_type  mem_ff [DEPTH];
   value_type  rdata_ff;
   action_type act_ff;
   index_type  idx_ff;
   value_type  val_ff;
   index_type  ptr_ff, ptr_in;
   count_type  count_ff, count_in;
   count_type  cap_ff;
   value_type  read_value_ff;
   status_type status_ff;

   status_type status;
   logic       idx_lt_n;
   logic       idx_lt_depth;
   logic       n_le_depth;
   logic       full;
   logic       is_insert;
   logic       is_erase;
   logic       is_append;
   logic       is_write_act;
   logic       wr_en;
   index_type  wr_pos;
   index_type  rd_pos;
   value_type  wr_data;
   logic [INDEX_W:0] ptr_next_up;

   // Request checks against the count and the capacity in force.
   always_comb begin
      idx_lt_n     = (idx_ff < count_ff);
      idx_lt_depth = (32'(idx_ff) < 32'(DEPTH));
      n_le_depth   = (32'(count_ff) <= 32'(DEPTH));
      full         = (count_ff >= cap_ff) || (32'(count_ff) >= 32'(DEPTH));
      unique case (act_ff) inside
         ACT_GET, ACT_SET: begin
            status = (idx_lt_n && idx_lt_depth) ? ST_OK : ST_RANGE;
         end
         ACT_APPEND: begin
            status = full ? ST_FULL : ST_OK;
         end
         ACT_INSERT: begin
            if (idx_ff > count_ff) begin
               status = ST_RANGE;
            end else begin
               status = full ? ST_FULL : ST_OK;
            end
         end
         ACT_ERASE: begin
            status = (idx_lt_n && n_le_depth) ? ST_OK : ST_RANGE;
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   assign is_insert    = (act_ff == ACT_INSERT);
   assign is_erase     = (act_ff == ACT_ERASE);
   assign is_append    = (act_ff == ACT_APPEND);
   assign is_write_act = (act_ff == ACT_SET) || is_append || is_insert;
   assign ptr_next_up  = {1'b0, ptr_ff} + 8'd1;

   always_comb begin
      sts.ok       = (status == ST_OK);
      sts.is_get   = (act_ff == ACT_GET);
      sts.is_shift = is_insert || is_erase;
      if (is_insert) begin
         sts.shift_more = (ptr_ff > idx_ff);
      end else begin
         sts.shift_more = (ptr_next_up < {1'b0, count_ff});
      end
   end

   // Insert moves elements up from the end; erase moves them down from the index.
   always_comb begin
      if (sts.is_get) begin
         rd_pos = idx_ff;
      end else if (is_insert) begin
         rd_pos = ptr_ff - 7'd1;
      end else begin
         rd_pos = ptr_next_up[INDEX_W-1:0];
      end
   end

   always_comb begin
      wr_en   = cmd.shift_wr || (cmd.commit && sts.ok && is_write_act);
      wr_data = cmd.shift_wr ? rdata_ff : val_ff;
      if (cmd.shift_wr) begin
         wr_pos = ptr_ff;
      end else if (is_append) begin
         wr_pos = count_ff;
      end else begin
         wr_pos = idx_ff;
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_init) begin
         ptr_in = is_insert ? count_ff : idx_ff;
      end else if (cmd.shift_wr) begin
         ptr_in = is_insert ? (ptr_ff - 7'd1) : ptr_next_up[INDEX_W-1:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.commit && sts.ok) begin
         if (is_append || is_insert) begin
            count_in = count_ff + 7'd1;
         end else if (is_erase) begin
            count_in = count_ff - 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[ADDR_W'(wr_pos)] <= wr_data;
      end
      if (cmd.rd) begin
         rdata_ff <= mem_ff[ADDR_W'(rd_pos)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         idx_ff <= req_index;
         val_ff <= req_value;
      end
      ptr_ff <= ptr_in;
      if (cmd.commit) begin
         read_value_ff <= (sts.is_get && sts.ok) ? rdata_ff : '0;
         status_ff     <= status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         count_ff <= count_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_read_value = read_value_ff;
   assign rsp_status     = status_ff;
   assign rsp_count      = count_ff;

`ifndef SYNTH
   // The count never grows past the store.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(DEPTH))
      else $error("element count exceeds store depth");

   // The count moves only on a commit.
   a_count_on_commit: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> $past(cmd.commit))
      else $error("element count changed outside a commit");

   // A failed request leaves the count alone.
   a_fail_no_change: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !sts.ok) |=> (count_ff == $past(count_ff)))
      else $error("failed request changed the count");

   // Element moves happen only for a checked insert or erase.
   a_shift_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_wr |-> (sts.ok && sts.is_shift))
      else $error("element move outside a valid insert or erase");
`endif

endmodule

`default_nettype wire

// File: bench/indexed_list_buffer_unit_test.sv
// Self-checking bench for the indexed list buffer: directed and random list traffic.
`timescale 1ns / 100ps

module indexed_list_buffer_unit_test;
   import ilb_pkg::*;

   localparam int LIST_DEPTH = 64;

   // The action field is three bits wide. Codes past erase are spare, and the
   // block must answer them with an ok status and leave the list alone.
   localparam action_type ACT_SPARE_A = 3'd5;
   localparam action_type ACT_SPARE_C = 3'd7;

   // How long the receiver refuses replies during the pressure phase. That is
   // far longer than one request takes, so the block holds a finished reply
   // and has to stop taking new requests.
   localparam int LONG_STALL_CYCLES = 300;

   // Mirror of the list contents. Every accepted request is applied here at
   // its handshake, and the reply that the request should produce is queued.
   class list_mirror;
      typedef struct {
         value_type  read_value;
         status_type status;
         count_type  count;
      } list_reply_type;

      value_type      words [LIST_DEPTH];
      count_type      count_now = '0;
      count_type      capacity  = CAP_RESET;
      list_reply_type expected_replies [$];
      int             mismatch_count = 0;

      function int pending();
         return expected_replies.size();
      endfunction

      function void note_request(action_type act, index_type idx, value_type val);
         list_reply_type r;
         int n   = count_now;
         int lim = (capacity > LIST_DEPTH) ? LIST_DEPTH : capacity;
         r.read_value = '0;
         r.status     = ST_OK;
         case (act)
            ACT_GET: begin
               if (idx < n) r.read_value = words[idx];
               else r.status = ST_RANGE;
            end
            ACT_SET: begin
               if (idx < n) words[idx] = val;
               else r.status = ST_RANGE;
            end
            ACT_APPEND: begin
               if (n >= lim) begin
                  r.status = ST_FULL;
               end else begin
                  words[n]  = val;
                  count_now = count_type'(n + 1);
               end
            end
            ACT_INSERT: begin
               // A bad index takes precedence over a full list.
               if (idx > n) begin
                  r.status = ST_RANGE;
               end else if (n >= lim) begin
                  r.status = ST_FULL;
               end else begin
                  for (int i = n; i > idx; i--) words[i] = words[i-1];
                  words[idx] = val;
                  count_now  = count_type'(n + 1);
               end
            end
            ACT_ERASE: begin
               if (idx < n) begin
                  for (int i = idx; i < n - 1; i++) words[i] = words[i+1];
                  count_now = count_type'(n - 1);
               end else begin
                  r.status = ST_RANGE;
               end
            end
            default: begin
            end
         endcase
         r.count = count_now;
         expected_replies.push_back(r);
      endfunction

      function void check_reply(value_type rv, status_type st, count_type cnt);
         list_reply_type e;
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected reply: read_value %0d status %0d count %0d",
                     $time, rv, st, cnt);
            mismatch_count++;
            return;
         end
         e = expected_replies.pop_front();
         if (rv !== e.read_value) begin
            $display("%0t: read_value mismatch: expected %0d, actual %0d",
                     $time, e.read_value, rv);
            mismatch_count++;
         end
         if (st !== e.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, st);
            mismatch_count++;
         end
         if (cnt !== e.count) begin
            $display("%0t: count mismatch: expected %0d, actual %0d", $time, e.count, cnt);
            mismatch_count++;
         end
      endfunction
   endclass

   logic      clock;
   logic      reset;
   logic      csr_wr_en;
   count_type csr_wr_data;

   ilb_req_if req_if ();
   ilb_rsp_if rsp_if ();

   list_mirror mirror = new();

   // Both sides read these. steady_flow removes all idle cycles for one
   // phase, and long_stall_due asks the receiver for one long hold-off.
   bit steady_flow    = 1'b0;
   bit long_stall_due = 1'b0;

   indexed_list_buffer_unit #(.DEPTH(LIST_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The bench quits here if the block hangs. The timeout leaves ample
   // margin over the slowest correct run.
   initial begin
      #4_000_000;
      $display("%0t: run timed out", $time);
      $display("Simulation FAILED");
      $finish;
   end

   // Presents one request and returns at the edge where it is accepted. Valid
   // stays high afterward, so a request with no gap before it follows without
   // a bubble. The caller lowers valid once the stream pauses.
   task automatic send_request(input action_type act, input index_type idx,
                               input value_type val);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.action <= act;
      req_if.index  <= idx;
      req_if.value  <= val;
      do @(posedge clock); while (!req_if.ready);
      mirror.note_request(act, idx, val);
   endtask

   // The capacity register may only change while the block is idle. This
   // task stops the request stream and waits until every reply is back.
   task automatic write_capacity(input count_type cap);
      req_if.valid <= 1'b0;
      while (mirror.pending() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mirror.capacity = cap;
      @(posedge clock);
   endtask

   // One phase of random traffic. grow_pct and erase_pct set the shares of
   // append/insert and of erase. Get and set take the rest, apart from a
   // small share of spare codes. Most indexes are legal for the current
   // count so that requests get past the range check and move data. The rest
   // cover the whole index field.
   task automatic run_phase(input int items, input int grow_pct, input int erase_pct);
      action_type act;
      index_type  idx;
      value_type  val;
      int         roll;
      int         n;
      for (int k = 0; k < items; k++) begin
         n    = mirror.count_now;
         roll = $urandom_range(0, 99);
         if (roll < 2) act = action_type'($urandom_range(ACT_SPARE_A, ACT_SPARE_C));
         else if (roll < 2 + grow_pct) act = $urandom_range(0, 1) ? ACT_APPEND : ACT_INSERT;
         else if (roll < 2 + grow_pct + erase_pct) act = ACT_ERASE;
         else act = $urandom_range(0, 1) ? ACT_GET : ACT_SET;

         if ($urandom_range(0, 9) == 0) idx = index_type'($urandom_range(0, 127));
         else if (act == ACT_INSERT) idx = index_type'($urandom_range(0, n));
         else if (n == 0) idx = '0;
         else idx = index_type'($urandom_range(0, n - 1));

         case ($urandom_range(0, 15))
            0: val = value_type'(32'h8000_0000);
            1: val = value_type'(32'h7FFF_FFFF);
            2: val = '0;
            3: val = '1;
            default: val = value_type'($urandom);
         endcase
         send_request(act, idx, val);
      end
   endtask

   // Receiver. Before each reply it may first hold ready low for a random
   // stretch, but not during the steady phase. On request it adds one long
   // hold-off. It then holds ready high until a reply is taken and checks it.
   initial begin
      int hold;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         hold = steady_flow ? 0 : $urandom_range(0, 4);
         if (long_stall_due) begin
            long_stall_due = 1'b0;
            hold += LONG_STALL_CYCLES;
         end
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         mirror.check_reply(rsp_if.read_value, rsp_if.status, rsp_if.count);
      end
   end

   // Main sequence: reset, directed cases, then phases of random traffic,
   // each phase under its own capacity setting.
   initial begin
      int guard;
      reset         <= 1'b1;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      req_if.valid  <= 1'b0;
      req_if.action <= ACT_GET;
      req_if.index  <= '0;
      req_if.value  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The list is empty, so get and erase at zero are out of range, and so
      // is an insert past the count.
      send_request(ACT_GET,    7'd0, '0);
      send_request(ACT_ERASE,  7'd0, '0);
      send_request(ACT_INSERT, 7'd1, '0);

      // Build a short list from extreme words, using insert at zero, appends
      // and an overwrite of the last element.
      send_request(ACT_INSERT, 7'd0, value_type'(32'h7FFF_FFFF));
      send_request(ACT_APPEND, 7'd0, value_type'(32'h8000_0000));
      send_request(ACT_APPEND, 7'd0, '0);
      send_request(ACT_APPEND, 7'd0, '1);
      send_request(ACT_SET,    7'd3, value_type'(32'h5A5A_5A5A));

      // Insert at the end position, which equals the count, then in the middle.
      send_request(ACT_INSERT, 7'd4, value_type'(32'h1234_5678));
      send_request(ACT_INSERT, 7'd1, value_type'(32'hA5A5_A5A5));
      send_request(ACT_GET,    7'd0, '0);
      send_request(ACT_GET,    7'd1, '0);
      send_request(ACT_GET,    7'd5, '0);

      // Indexes at and past the count, up to the top of the index field.
      send_request(ACT_GET,    7'd64,  '0);
      send_request(ACT_SET,    7'd127, '1);
      send_request(ACT_ERASE,  7'd6,   '0);

      // Erase the first element, then the last one.
      send_request(ACT_ERASE,  7'd0, '0);
      send_request(ACT_ERASE,  7'd4, '0);

      // Spare action codes are ignored, whatever their fields hold.
      send_request(ACT_SPARE_A,             7'd127, '1);
      send_request(action_type'(ACT_SPARE_A + 3'd1), 7'd0, '1);
      send_request(ACT_SPARE_C,             7'd127, '0);
      send_request(ACT_GET,    7'd2, '0);

      // With a capacity of zero, every append and insert reports full. An
      // insert that is also out of range reports the range error.
      write_capacity(7'd0);
      send_request(ACT_APPEND, 7'd0, value_type'(32'h0BAD_CAFE));
      send_request(ACT_INSERT, 7'd0, value_type'(32'h0BAD_CAFE));
      send_request(ACT_INSERT, 7'd9, value_type'(32'h0BAD_CAFE));

      // The capacity now sits below the count. The elements stay, and growth
      // stays blocked until the count falls below the limit.
      write_capacity(7'd2);
      send_request(ACT_APPEND, 7'd0, '1);
      send_request(ACT_ERASE,  7'd0, '0);
      send_request(ACT_ERASE,  7'd0, '0);
      send_request(ACT_INSERT, 7'd0, '1);

      // A capacity above the store depth limits at the depth. This phase leans
      // on growth, so it fills the whole store and then runs into full.
      write_capacity(7'd127);
      run_phase(150, 70, 5);

      // Reset value again, with no idle cycles on either side.
      write_capacity(CAP_RESET);
      steady_flow = 1'b1;
      run_phase(150, 35, 30);
      steady_flow = 1'b0;

      // Smallest real capacity, set while the list is likely far above it.
      write_capacity(7'd1);
      run_phase(80, 40, 20);

      // One past the depth. The receiver holds off for a long stretch while
      // requests keep coming, so the block backs up and stalls its input.
      write_capacity(7'd65);
      long_stall_due = 1'b1;
      run_phase(150, 50, 10);

      write_capacity(7'd0);
      run_phase(60, 30, 30);

      write_capacity(7'd16);
      run_phase(150, 30, 40);

      for (int p = 0; p < 3; p++) begin
         write_capacity(count_type'($urandom_range(1, LIST_DEPTH)));
         run_phase(150, 40, 30);
      end

      // Drain the list under the full capacity.
      write_capacity(7'd64);
      run_phase(130, 20, 60);

      req_if.valid <= 1'b0;
      guard = 0;
      while (mirror.pending() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      // Keep the clock running so that a stray extra reply would still be seen.
      repeat (20) @(posedge clock);
      if (mirror.pending() != 0) begin
         $display("%0t: %0d expected replies never arrived", $time, mirror.pending());
         mirror.mismatch_count++;
      end

      if (mirror.mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
